FILE: rtl/core/iact_pkg.sv
// ============================================================================
// iact_pkg
// shared types, command and status codes for the in-flight conflict tracker
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package iact_pkg;

  localparam int ADDR_BITS     = 24;
  localparam int PAIR_BITS     = 2 * ADDR_BITS;
  localparam int CMD_BITS      = 2;
  localparam int STATUS_BITS   = 2;
  localparam int COUNT_BITS    = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [CMD_BITS-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RETIRE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CHECK  = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [ADDR_BITS-1:0] operand_a_address;
    logic [ADDR_BITS-1:0] operand_b_address;
    logic [ADDR_BITS-1:0] check_address;
  } in_word_t;

  typedef struct packed {
    logic                   conflict;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  in_flight_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_needed;
    logic scan_done;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/inflight_address_conflict_tracker.sv
// ============================================================================
// inflight_address_conflict_tracker
// fifo of in-flight operand address pairs with a load address conflict check
// ============================================================================
// usage
//   in channel : in_valid / in_stall carry one word per accepted edge; the
//                command field selects push (append operand pair), retire
//                (drop the oldest pair) or check (compare check_address)
//   out channel: out_valid / out_stall carry exactly one result word per
//                input word, in order: conflict flag, status, jobs in flight
//   sequence   : push, retire and unused codes go from execute straight to
//                the result hand-off; a check with jobs in flight first
//                scans the store, one ram read per stored entry, and stops
//                at the first match
//   pacing     : one word at a time, held off by in_stall until its result
//                is loaded; the scan uses the single read port of the store
//   reset      : rst_n low empties the fifo and drops any pending result;
//                the store itself is not cleared, only in-flight entries are
//                ever read
//   stall      : a stalled result holds in the output register; the next
//                word is still taken and worked on, and waits for the slot
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module inflight_address_conflict_tracker #(
  parameter int DEPTH = iact_pkg::DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire iact_pkg::in_word_t in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output iact_pkg::out_word_t     out_word
);

  // command and status between the two halves
  iact_pkg::ctrl_cmd_t  cmd;
  iact_pkg::dp_status_t dp_status;

  // sequencer: idle, execute, scan store, hand result to output register
  iact_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall_r (in_stall),
    .status     (dp_status),
    .cmd        (cmd)
  );

  // pointers, operand ram, address compare and output register
  iact_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .cmd         (cmd),
    .status      (dp_status),
    .out_stall   (out_stall),
    .out_valid_r (out_valid),
    .out_word_r  (out_word)
  );

endmodule

`default_nettype wire

FILE: rtl/core/iact_ram.sv
// ============================================================================
// iact_ram
// generic single write, single read ram with registered read data
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module iact_ram #(
  parameter int WIDTH = iact_pkg::PAIR_BITS,
  parameter int DEPTH = iact_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/iact_dp.sv
// ============================================================================
// iact_dp
// datapath: fifo pointers, operand store, serial address scan, result word
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module iact_dp #(
  parameter int DEPTH = iact_pkg::DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire iact_pkg::in_word_t  in_word,
  input  wire iact_pkg::ctrl_cmd_t cmd,
  output iact_pkg::dp_status_t     status,
  input  wire logic                out_stall,
  output logic                     out_valid_r,
  output iact_pkg::out_word_t      out_word_r
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  iact_pkg::in_word_t                in_r;
  logic [IDX_W-1:0]                  oldest_r, oldest_nxt;
  logic [IDX_W-1:0]                  next_r, next_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [IDX_W-1:0]                  scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]                  left_r, left_nxt;
  logic                              rd_valid_r;
  logic                              conflict_r, conflict_nxt;
  logic [iact_pkg::STATUS_BITS-1:0]  res_status_r, res_status_nxt;
  logic                              ram_we;
  logic                              ram_re;
  logic [iact_pkg::PAIR_BITS-1:0]    ram_rdata;
  logic                              hit;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  iact_ram #(
    .WIDTH (iact_pkg::PAIR_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (next_r),
    .wdata   ({in_r.operand_b_address, in_r.operand_a_address}),
    .re      (ram_re),
    .raddr   (scan_idx_r),
    .rdata_r (ram_rdata)
  );

  // compare on the entry read in the previous cycle
  assign hit = rd_valid_r &&
               ((ram_rdata[iact_pkg::ADDR_BITS-1:0] == in_r.check_address) ||
                (ram_rdata[iact_pkg::PAIR_BITS-1:iact_pkg::ADDR_BITS] ==
                 in_r.check_address));

  assign status.scan_needed = (in_r.command == iact_pkg::CMD_CHECK) && (count_r != '0);
  assign status.scan_done   = rd_valid_r && (hit || (left_r == '0));
  assign status.slot_free   = !out_valid_r || !out_stall;

  assign ram_re = cmd.scan && (left_r != '0) && !status.scan_done;

  always_comb begin
    oldest_nxt     = oldest_r;
    next_nxt       = next_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    left_nxt       = left_r;
    conflict_nxt   = conflict_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    if (cmd.exec) begin
      res_status_nxt = iact_pkg::STATUS_OK;
      conflict_nxt   = 1'b0;
      scan_idx_nxt   = oldest_r;
      left_nxt       = count_r;
      case (in_r.command)
        iact_pkg::CMD_PUSH: begin
          if (count_r == CNT_W'(DEPTH)) begin
            res_status_nxt = iact_pkg::STATUS_FULL;
          end else begin
            ram_we    = 1'b1;
            next_nxt  = advance(next_r);
            count_nxt = count_r + 1'b1;
          end
        end
        iact_pkg::CMD_RETIRE: begin
          if (count_r == '0) begin
            res_status_nxt = iact_pkg::STATUS_EMPTY;
          end else begin
            oldest_nxt = advance(oldest_r);
            count_nxt  = count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (ram_re) begin
      scan_idx_nxt = advance(scan_idx_r);
      left_nxt     = left_r - 1'b1;
    end
    if (cmd.scan && hit) begin
      conflict_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      next_r      <= '0;
      count_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      oldest_r   <= oldest_nxt;
      next_r     <= next_nxt;
      count_r    <= count_nxt;
      rd_valid_r <= ram_re;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_word;
    end
    scan_idx_r   <= scan_idx_nxt;
    left_r       <= left_nxt;
    conflict_r   <= conflict_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load_out) begin
      out_word_r.conflict        <= conflict_r;
      out_word_r.status          <= res_status_r;
      out_word_r.in_flight_count <= iact_pkg::COUNT_BITS'(count_r);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/iact_ctrl.sv
// ============================================================================
// iact_ctrl
// controller: sequences accept, execute, scan and result hand-off
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module iact_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall_r,
  input  wire iact_pkg::dp_status_t status,
  output iact_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.scan_needed ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/iact_checker.sv
// ============================================================================
// iact_checker
// port level checks for the in-flight conflict tracker, bound to the top
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module iact_checker #(
  parameter int DEPTH = iact_pkg::DEPTH_DEFAULT
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire iact_pkg::out_word_t out_word
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // one word at a time: an accepted word blocks the next edge
  a_seq_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted back to back");

  // a refused push only happens with the store full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == iact_pkg::STATUS_FULL) |->
      out_word.in_flight_count == iact_pkg::COUNT_BITS'(DEPTH))
    else $error("push refused below capacity");

  // a refused retire leaves nothing in flight, and never flags a conflict
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == iact_pkg::STATUS_EMPTY) |->
      (out_word.in_flight_count == '0) && !out_word.conflict)
    else $error("retire refused with jobs in flight");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind inflight_address_conflict_tracker iact_checker #(
  .DEPTH (DEPTH)
) u_iact_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

FILE: tb/inflight_address_conflict_tracker_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// inflight_address_conflict_tracker_tb
// self-checking bench: a queue-fed driver offers push, retire, check and spare
// code words, a monitor predicts each result from its own copy of the in-flight
// store and compares every result word field by field, with random idling on both sides
// ============================================================================

module inflight_address_conflict_tracker_tb;

  // the package has no name for the spare command code
  localparam logic [iact_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int DEPTH           = iact_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_WORDS    = 1200;
  localparam int IDLE_LIMIT      = 5000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RECENT_KEPT     = 32;
  localparam logic [iact_pkg::ADDR_BITS-1:0] ADDR_TOP = '1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  iact_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  iact_pkg::out_word_t out_word;

  inflight_address_conflict_tracker #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // bench copy of the in-flight store, advanced once per accepted word
  logic [iact_pkg::PAIR_BITS-1:0] tracked_pairs [DEPTH];
  int unsigned oldest_slot = 0;
  int unsigned next_slot   = 0;
  int unsigned jobs_held   = 0;

  iact_pkg::in_word_t  pending_words [$];
  iact_pkg::out_word_t expected_results [$];

  // addresses for the generator: a few hot ones so checks hit often
  logic [iact_pkg::ADDR_BITS-1:0] hot_addrs [8];
  logic [iact_pkg::ADDR_BITS-1:0] recent_addrs [$];

  int unsigned words_taken = 0;
  int unsigned mismatches  = 0;
  logic        in_taken    = 1'b0;
  int unsigned send_gap    = 0;
  int unsigned send_quiet  = 0;
  int unsigned recv_quiet  = 0;
  int unsigned hold_left   = 0;
  int unsigned pressure_left = 0;
  int unsigned pressure_done = 0;

  // result of one word, moving the bench store along with it
  function automatic iact_pkg::out_word_t track_word(input iact_pkg::in_word_t w);
    iact_pkg::out_word_t r;
    int unsigned         slot;
    r = '0;
    r.conflict = 1'b0;
    r.status   = iact_pkg::STATUS_OK;
    case (w.command)
      iact_pkg::CMD_PUSH: begin
        if (jobs_held >= DEPTH) begin
          r.status = iact_pkg::STATUS_FULL;
        end else begin
          tracked_pairs[next_slot] = {w.operand_b_address, w.operand_a_address};
          next_slot = (next_slot + 1) % DEPTH;
          jobs_held++;
        end
      end
      iact_pkg::CMD_RETIRE: begin
        if (jobs_held == 0) begin
          r.status = iact_pkg::STATUS_EMPTY;
        end else begin
          oldest_slot = (oldest_slot + 1) % DEPTH;
          jobs_held--;
        end
      end
      iact_pkg::CMD_CHECK: begin
        // only entries still in flight take part in the compare
        slot = oldest_slot;
        for (int n = 0; n < jobs_held; n++) begin
          if (tracked_pairs[slot][iact_pkg::ADDR_BITS-1:0] == w.check_address ||
              tracked_pairs[slot][iact_pkg::PAIR_BITS-1:iact_pkg::ADDR_BITS] ==
              w.check_address) begin
            r.conflict = 1'b1;
          end
          slot = (slot + 1) % DEPTH;
        end
      end
      default: begin
      end
    endcase
    r.in_flight_count = iact_pkg::COUNT_BITS'(jobs_held);
    return r;
  endfunction

  // idle length: mostly none or short, a few long, now and then a quiet run
  function automatic int unsigned pick_gap(inout int unsigned quiet_span);
    int unsigned roll;
    if (quiet_span > 0) begin
      quiet_span--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      quiet_span = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [iact_pkg::ADDR_BITS-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ADDR_TOP;
      2, 3, 4: return hot_addrs[$urandom_range(0, 7)];
      default: return iact_pkg::ADDR_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_word(input logic [iact_pkg::CMD_BITS-1:0]  cmd,
                            input logic [iact_pkg::ADDR_BITS-1:0] a,
                            input logic [iact_pkg::ADDR_BITS-1:0] b,
                            input logic [iact_pkg::ADDR_BITS-1:0] chk);
    iact_pkg::in_word_t w;
    w.command           = cmd;
    w.operand_a_address = a;
    w.operand_b_address = b;
    w.check_address     = chk;
    pending_words.insert(pending_words.size(), w);
    if (cmd == iact_pkg::CMD_PUSH) begin
      recent_addrs.insert(recent_addrs.size(), a);
      recent_addrs.insert(recent_addrs.size(), b);
      while (recent_addrs.size() > RECENT_KEPT) void'(recent_addrs.pop_front());
    end
  endtask

  // driver: new word at the falling edge, held until the monitor saw it taken
  always @(negedge clk) begin
    logic               next_valid;
    iact_pkg::in_word_t next_word;
    next_valid = in_valid;
    next_word  = in_word;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_valid) send_gap = pick_gap(send_quiet);
      if (send_gap > 0) begin
        send_gap--;
        next_valid = 1'b0;
      end else if (pending_words.size() > 0) begin
        next_word  = pending_words.pop_front();
        next_valid = 1'b1;
      end else begin
        next_valid = 1'b0;
      end
    end
    in_valid <= next_valid;
    in_word  <= next_word;
  end

  // receiver stall: random holds, plus two long hold-offs that fill the block
  always @(negedge clk) begin
    logic next_stall;
    next_stall = 1'b0;
    if (rst_n) begin
      if (pressure_left == 0 && ((pressure_done == 0 && words_taken >= 300) ||
                                 (pressure_done == 1 && words_taken >= 900))) begin
        pressure_left = PRESSURE_CYCLES;
        pressure_done++;
      end
      if (pressure_left > 0) begin
        pressure_left--;
        next_stall = 1'b1;
      end else begin
        if (hold_left == 0) hold_left = pick_gap(recv_quiet);
        if (hold_left > 0) begin
          hold_left--;
          next_stall = 1'b1;
        end
      end
    end
    out_stall <= next_stall;
  end

  // monitor: predict on each taken input word, check each taken result word
  always @(posedge clk) begin
    iact_pkg::out_word_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), track_word(in_word));
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %p", out_word);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_word.conflict !== want.conflict) begin
            $error("conflict: expected %0b, got %0b", want.conflict, out_word.conflict);
            mismatches++;
          end
          if (out_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            mismatches++;
          end
          if (out_word.in_flight_count !== want.in_flight_count) begin
            $error("in_flight_count: expected %0d, got %0d",
                   want.in_flight_count, out_word.in_flight_count);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("inflight_address_conflict_tracker_tb failed");
    $finish;
  end

  initial begin
    int unsigned total_words;
    int unsigned push_bias;
    int unsigned roll;
    logic [iact_pkg::CMD_BITS-1:0]  cmd;
    logic [iact_pkg::ADDR_BITS-1:0] chk;

    for (int i = 0; i < 8; i++) hot_addrs[i] = iact_pkg::ADDR_BITS'($urandom);

    // directed: empty store, spare code, extremes, fill to full, refusal
    queue_word(iact_pkg::CMD_RETIRE, ADDR_TOP, ADDR_TOP, ADDR_TOP);
    queue_word(iact_pkg::CMD_CHECK, '0, '0, '0);
    queue_word(CMD_UNUSED, ADDR_TOP, ADDR_TOP, ADDR_TOP);
    queue_word(iact_pkg::CMD_PUSH, '0, ADDR_TOP, 24'h5a5a5a);
    queue_word(iact_pkg::CMD_CHECK, 24'h111111, 24'h222222, '0);
    queue_word(iact_pkg::CMD_CHECK, 24'h333333, 24'h444444, ADDR_TOP);
    queue_word(iact_pkg::CMD_CHECK, ADDR_TOP, '0, 24'h123456);
    for (int i = 1; i < DEPTH; i++) begin
      queue_word(iact_pkg::CMD_PUSH, 24'ha5a5a5 ^ iact_pkg::ADDR_BITS'(i),
                 24'h800000 | iact_pkg::ADDR_BITS'(i << 4),
                 iact_pkg::ADDR_BITS'($urandom));
    end
    queue_word(iact_pkg::CMD_PUSH, 24'h777777, 24'h888888, '0);
    // newest entry is still found when the store is full
    queue_word(iact_pkg::CMD_CHECK, '0, '0, 24'ha5a5a5 ^ iact_pkg::ADDR_BITS'(DEPTH - 1));
    queue_word(iact_pkg::CMD_RETIRE, '0, '0, '0);
    // the pair at the old head has gone
    queue_word(iact_pkg::CMD_CHECK, '0, '0, '0);

    // random: phases that lean to filling, balance or draining
    push_bias = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 48 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 85;
          1:       push_bias = 50;
          default: push_bias = 15;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = CMD_UNUSED;
      else if (roll < 38) cmd = iact_pkg::CMD_CHECK;
      else if ($urandom_range(0, 99) < push_bias) cmd = iact_pkg::CMD_PUSH;
      else cmd = iact_pkg::CMD_RETIRE;
      if (cmd == iact_pkg::CMD_CHECK && recent_addrs.size() > 0 &&
          $urandom_range(0, 9) < 4) begin
        chk = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      end else begin
        chk = pick_addr();
      end
      queue_word(cmd, pick_addr(), pick_addr(), chk);
    end
    total_words = pending_words.size();

    // synchronous reset, released at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (words_taken == total_words);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("inflight_address_conflict_tracker_tb passed");
    end else begin
      $display("inflight_address_conflict_tracker_tb failed");
    end
    $finish;
  end

endmodule
